// File: design/dag_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dag_pkg;

  // Default widths of the level accumulator
  localparam int unsigned LEVEL_BITS_DEF = 12;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Reset value of every step register, 1.0 in 12.16
  localparam int unsigned STEP_RESET = 32'd65536;

  typedef enum logic [1:0] {
    PH_LOW  = 2'd0,
    PH_RISE = 2'd1,
    PH_HIGH = 2'd2,
    PH_FALL = 2'd3
  } dag_phase_e;

  // Code three means nothing of its own and behaves as a tick
  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_HIGH = 2'd1,
    ACT_LOW  = 2'd2
  } dag_action_e;

  typedef enum logic [1:0] {
    REG_ATTACK_A  = 2'd0,
    REG_RELEASE_A = 2'd1,
    REG_ATTACK_B  = 2'd2,
    REG_RELEASE_B = 2'd3
  } dag_reg_e;

  typedef struct packed {
    logic        channel;
    dag_action_e action;
  } dag_req_t;

endpackage

`default_nettype wire

// File: design/dual_attack_release_gate_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// in        slave      in_valid_i/in_stall_o  in_channel_i, in_action_i
// out       master     out_valid_o/out_stall_i out_gate_level_o
// cfg       APB slave  psel/penable/pready    paddr, pwdata, prdata
//
// One transaction per cycle sustained while out_stall_i is low; results are registered.
// The gate update (one add or subtract, clamp, phase step) sits between the
// input register and the result register, so same-gate items follow back to back.
// Reset puts both gates in the low phase at level zero and every step to 1.0.
// A stalled result holds the update stage; one more input is still taken.

module dual_attack_release_gate_core #(
  parameter int unsigned LEVEL_BITS = dag_pkg::LEVEL_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dag_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                                     clk_i,
  input  wire logic                                                     rst_ni,
  input  wire logic                                                     in_valid_i,
  output logic                                                          in_stall_o,
  input  wire logic                                                     in_channel_i,
  input  wire logic [1:0]                                               in_action_i,
  output logic                                                          out_valid_o,
  input  wire logic                                                     out_stall_i,
  output logic      [LEVEL_BITS-1:0]                                    out_gate_level_o,
  input  wire logic                                                     psel,
  input  wire logic                                                     penable,
  input  wire logic                                                     pwrite,
  input  wire logic [(((LEVEL_BITS + FRAC_BITS) > 32) ? 3 : 2) + 1:0]  paddr,
  input  wire logic [(((LEVEL_BITS + FRAC_BITS) > 32) ? 64 : 32) - 1:0] pwdata,
  output logic      [(((LEVEL_BITS + FRAC_BITS) > 32) ? 64 : 32) - 1:0] prdata,
  output logic                                                          pready
);

  localparam int unsigned AccBits = LEVEL_BITS + FRAC_BITS;

  logic [1:0][AccBits-1:0] attack_step, release_step;

  logic              s1_valid_q, s1_valid_d;
  dag_pkg::dag_req_t s1_req_q;
  logic              s1_adv, in_acc;
  logic              out_valid_q, out_valid_d;
  logic [LEVEL_BITS-1:0] level_q, level_new;

  dag_cfg_regs #(
    .LEVEL_BITS(LEVEL_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .attack_step_o (attack_step),
    .release_step_o(release_step)
  );

  dag_gate_core #(
    .LEVEL_BITS(LEVEL_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_gate (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .upd_en_i      (s1_adv),
    .req_i         (s1_req_q),
    .attack_step_i (attack_step),
    .release_step_i(release_step),
    .level_o       (level_new)
  );

  // Advance the update stage when the result register is free or draining
  assign s1_adv     = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc)      s1_valid_d = 1'b1;
    else if (s1_adv) s1_valid_d = 1'b0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv)            out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q.channel <= in_channel_i;
      s1_req_q.action  <= dag_pkg::dag_action_e'(in_action_i);
    end
    if (s1_adv) level_q <= level_new;
  end

  assign out_valid_o      = out_valid_q;
  assign out_gate_level_o = level_q;

endmodule

`default_nettype wire

// File: design/dag_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module dag_cfg_regs #(
  parameter int unsigned LEVEL_BITS = dag_pkg::LEVEL_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dag_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                                     clk_i,
  input  wire logic                                                     rst_ni,
  input  wire logic                                                     psel,
  input  wire logic                                                     penable,
  input  wire logic                                                     pwrite,
  input  wire logic [(((LEVEL_BITS + FRAC_BITS) > 32) ? 3 : 2) + 1:0]  paddr,
  input  wire logic [(((LEVEL_BITS + FRAC_BITS) > 32) ? 64 : 32) - 1:0] pwdata,
  output logic      [(((LEVEL_BITS + FRAC_BITS) > 32) ? 64 : 32) - 1:0] prdata,
  output logic                                                          pready,
  output logic      [1:0][LEVEL_BITS + FRAC_BITS - 1:0]                 attack_step_o,
  output logic      [1:0][LEVEL_BITS + FRAC_BITS - 1:0]                 release_step_o
);

  localparam int unsigned AccBits = LEVEL_BITS + FRAC_BITS;
  localparam int unsigned DataW   = (AccBits > 32) ? 64 : 32;
  localparam int unsigned AddrLsb = (AccBits > 32) ? 3 : 2;
  localparam int unsigned AddrW   = AddrLsb + 2;

  logic [1:0][AccBits-1:0] attack_q, release_q;
  dag_pkg::dag_reg_e       reg_idx;
  logic                    wr_en;

  assign reg_idx = dag_pkg::dag_reg_e'(paddr[AddrW-1:AddrLsb]);
  assign wr_en   = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= {2{AccBits'(dag_pkg::STEP_RESET)}};
      release_q <= {2{AccBits'(dag_pkg::STEP_RESET)}};
    end else if (wr_en) begin
      case (reg_idx)
        dag_pkg::REG_ATTACK_A:  attack_q[0]  <= pwdata[AccBits-1:0];
        dag_pkg::REG_RELEASE_A: release_q[0] <= pwdata[AccBits-1:0];
        dag_pkg::REG_ATTACK_B:  attack_q[1]  <= pwdata[AccBits-1:0];
        dag_pkg::REG_RELEASE_B: release_q[1] <= pwdata[AccBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dag_pkg::REG_ATTACK_A:  prdata = DataW'(attack_q[0]);
      dag_pkg::REG_RELEASE_A: prdata = DataW'(release_q[0]);
      dag_pkg::REG_ATTACK_B:  prdata = DataW'(attack_q[1]);
      dag_pkg::REG_RELEASE_B: prdata = DataW'(release_q[1]);
      default:                prdata = '0;
    endcase
  end

  assign attack_step_o  = attack_q;
  assign release_step_o = release_q;

endmodule

`default_nettype wire

// File: design/dag_gate_core.sv
`timescale 1ns / 1ps
`default_nettype none

module dag_gate_core #(
  parameter int unsigned LEVEL_BITS = dag_pkg::LEVEL_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dag_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     upd_en_i,
  input  wire dag_pkg::dag_req_t                        req_i,
  input  wire logic [1:0][LEVEL_BITS + FRAC_BITS - 1:0] attack_step_i,
  input  wire logic [1:0][LEVEL_BITS + FRAC_BITS - 1:0] release_step_i,
  output logic      [LEVEL_BITS-1:0]                    level_o
);

  localparam int unsigned AccBits = LEVEL_BITS + FRAC_BITS;
  localparam logic [AccBits-1:0] FullScale = {{LEVEL_BITS{1'b1}}, {FRAC_BITS{1'b0}}};

  dag_pkg::dag_phase_e [1:0] phase_q;
  logic [1:0][AccBits-1:0]   acc_q;

  dag_pkg::dag_phase_e sel_phase, phase_d;
  logic [AccBits-1:0]  sel_acc, acc_d, atk, rel;
  logic [AccBits:0]    sum;
  logic                sum_full, rel_empty;

  assign sel_phase = phase_q[req_i.channel];
  assign sel_acc   = acc_q[req_i.channel];
  assign atk       = attack_step_i[req_i.channel];
  assign rel       = release_step_i[req_i.channel];
  assign sum       = {1'b0, sel_acc} + {1'b0, atk};
  assign sum_full  = (sum >= {1'b0, FullScale});
  assign rel_empty = (rel >= sel_acc);

  // Next phase
  always_comb begin
    phase_d = sel_phase;
    case (sel_phase)
      dag_pkg::PH_LOW: begin
        if (req_i.action == dag_pkg::ACT_HIGH) phase_d = dag_pkg::PH_RISE;
      end
      dag_pkg::PH_HIGH: begin
        if (req_i.action == dag_pkg::ACT_LOW) phase_d = dag_pkg::PH_FALL;
      end
      dag_pkg::PH_RISE: begin
        if (req_i.action == dag_pkg::ACT_LOW) phase_d = dag_pkg::PH_FALL;
        else if (sum_full)                    phase_d = dag_pkg::PH_HIGH;
      end
      dag_pkg::PH_FALL: begin
        if (req_i.action == dag_pkg::ACT_HIGH) phase_d = dag_pkg::PH_RISE;
        else if (rel_empty)                    phase_d = dag_pkg::PH_LOW;
      end
      default: phase_d = sel_phase;
    endcase
  end

  // Next level
  always_comb begin
    acc_d = sel_acc;
    case (sel_phase)
      dag_pkg::PH_LOW:  acc_d = '0;
      dag_pkg::PH_HIGH: acc_d = FullScale;
      dag_pkg::PH_RISE: begin
        if (req_i.action != dag_pkg::ACT_LOW) begin
          acc_d = sum_full ? FullScale : sum[AccBits-1:0];
        end
      end
      dag_pkg::PH_FALL: begin
        if (req_i.action != dag_pkg::ACT_HIGH) begin
          acc_d = rel_empty ? '0 : (sel_acc - rel);
        end
      end
      default: acc_d = sel_acc;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q[0] <= dag_pkg::PH_LOW;
      phase_q[1] <= dag_pkg::PH_LOW;
      acc_q      <= '0;
    end else if (upd_en_i) begin
      phase_q[req_i.channel] <= phase_d;
      acc_q[req_i.channel]   <= acc_d;
    end
  end

  assign level_o = acc_d[AccBits-1:FRAC_BITS];

  a_high_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q[0] != dag_pkg::PH_HIGH || acc_q[0] == FullScale) &&
    (phase_q[1] != dag_pkg::PH_HIGH || acc_q[1] == FullScale))
    else $error("gate in high phase without full-scale level");

  a_low_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q[0] != dag_pkg::PH_LOW || acc_q[0] == '0) &&
    (phase_q[1] != dag_pkg::PH_LOW || acc_q[1] == '0))
    else $error("gate in low phase with nonzero level");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd_en_i |=> $stable(phase_q) && $stable(acc_q))
    else $error("gate state changed without an update");

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ACC_W = dag_pkg::LEVEL_BITS_DEF + dag_pkg::FRAC_BITS_DEF;
  localparam logic [ACC_W-1:0] FULL_SCALE =
    ACC_W'((2 ** dag_pkg::LEVEL_BITS_DEF - 1) << dag_pkg::FRAC_BITS_DEF);
  // Undefined action code, handled as a tick
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int RAND_PHASES = 6;
  localparam int HOLD_CYCLES = 80;

  class gate_scoreboard;
    logic [ACC_W-1:0] attack_step[2];
    logic [ACC_W-1:0] release_step[2];
    dag_pkg::dag_phase_e phase[2];
    logic [ACC_W-1:0] accum[2];
    logic [dag_pkg::LEVEL_BITS_DEF-1:0] level_q[$];
    int errors;

    function new();
      for (int i = 0; i < 2; i++) begin
        attack_step[i] = ACC_W'(dag_pkg::STEP_RESET);
        release_step[i] = ACC_W'(dag_pkg::STEP_RESET);
        phase[i] = dag_pkg::PH_LOW;
        accum[i] = '0;
      end
      errors = 0;
    endfunction

    function void set_step(dag_pkg::dag_reg_e r, logic [31:0] v);
      case (r)
        dag_pkg::REG_ATTACK_A: attack_step[0] = v[ACC_W-1:0];
        dag_pkg::REG_RELEASE_A: release_step[0] = v[ACC_W-1:0];
        dag_pkg::REG_ATTACK_B: attack_step[1] = v[ACC_W-1:0];
        dag_pkg::REG_RELEASE_B: release_step[1] = v[ACC_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the addressed gate and queue its new level
    function void note_input(logic ch, logic [1:0] act);
      logic [ACC_W:0] acc;
      acc = {1'b0, accum[ch]};
      case (phase[ch])
        dag_pkg::PH_LOW: begin
          acc = '0;
          if (act == dag_pkg::ACT_HIGH) phase[ch] = dag_pkg::PH_RISE;
        end
        dag_pkg::PH_HIGH: begin
          acc = {1'b0, FULL_SCALE};
          if (act == dag_pkg::ACT_LOW) phase[ch] = dag_pkg::PH_FALL;
        end
        dag_pkg::PH_RISE: begin
          if (act == dag_pkg::ACT_LOW) begin
            phase[ch] = dag_pkg::PH_FALL;
          end else begin
            acc = acc + attack_step[ch];
            if (acc >= FULL_SCALE) begin
              acc = {1'b0, FULL_SCALE};
              phase[ch] = dag_pkg::PH_HIGH;
            end
          end
        end
        default: begin
          if (act == dag_pkg::ACT_HIGH) begin
            phase[ch] = dag_pkg::PH_RISE;
          end else if (release_step[ch] >= acc) begin
            acc = '0;
            phase[ch] = dag_pkg::PH_LOW;
          end else begin
            acc = acc - release_step[ch];
          end
        end
      endcase
      accum[ch] = acc[ACC_W-1:0];
      level_q.push_back(acc[ACC_W-1:dag_pkg::FRAC_BITS_DEF]);
    endfunction

    function void check_result(logic [dag_pkg::LEVEL_BITS_DEF-1:0] level);
      logic [dag_pkg::LEVEL_BITS_DEF-1:0] exp_level;
      if (level_q.size() == 0) begin
        $display("%0t: gate level %0d with no transaction outstanding", $time, level);
        errors++;
      end else begin
        exp_level = level_q.pop_front();
        if (exp_level !== level) begin
          $display("%0t: gate level mismatch, expected %0d, actual %0d",
                   $time, exp_level, level);
          errors++;
        end
      end
    endfunction

    function int pending();
      return level_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic in_channel_i;
  logic [1:0] in_action_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [dag_pkg::LEVEL_BITS_DEF-1:0] out_gate_level_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  bit quiet;
  bit hold_request;
  gate_scoreboard sb;

  dual_attack_release_gate_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_channel_i     (in_channel_i),
    .in_action_i      (in_action_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_gate_level_o (out_gate_level_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Check the result before noting the input taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_gate_level_o);
      if (in_valid_i && !in_stall_o) sb.note_input(in_channel_i, in_action_i);
    end
  end

  initial begin : sink
    int hold_cnt;
    hold_cnt = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 35);
      end
    end
  end

  task automatic offer(input logic ch, input logic [1:0] act);
    if (!quiet) begin
      while ($urandom_range(99) < 35) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_channel_i <= ch;
    in_action_i <= act;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Wait until every queued level has come back, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input dag_pkg::dag_reg_e r, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_step(r, v);
  endtask

  task automatic write_all(input logic [31:0] v);
    apb_write(dag_pkg::REG_ATTACK_A, v);
    apb_write(dag_pkg::REG_RELEASE_A, v);
    apb_write(dag_pkg::REG_ATTACK_B, v);
    apb_write(dag_pkg::REG_RELEASE_B, v);
  endtask

  function automatic logic [31:0] rand_step();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = 32'(FULL_SCALE);
      2: v = $urandom_range(1, 65535);
      3: v = $urandom_range(0, 32'(FULL_SCALE));
      default: v = $urandom_range(1 << 20, 1 << 24);
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int burst;
    int roll;
    logic ch;
    logic [1:0] act;
    sb = new();
    quiet = 1'b0;
    hold_request = 1'b0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_channel_i <= 1'b0;
    in_action_i <= dag_pkg::ACT_TICK;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default steps of one level per tick: walk gate A through the low, rise and fall phases
    offer(1'b0, dag_pkg::ACT_TICK);
    offer(1'b0, dag_pkg::ACT_LOW);
    offer(1'b0, dag_pkg::ACT_HIGH);
    offer(1'b0, dag_pkg::ACT_TICK);
    offer(1'b0, dag_pkg::ACT_TICK);
    offer(1'b0, ACT_SPARE);
    offer(1'b0, dag_pkg::ACT_LOW);
    offer(1'b0, dag_pkg::ACT_TICK);
    offer(1'b0, dag_pkg::ACT_HIGH);
    offer(1'b0, dag_pkg::ACT_TICK);
    offer(1'b0, dag_pkg::ACT_LOW);
    offer(1'b0, dag_pkg::ACT_TICK);
    offer(1'b0, dag_pkg::ACT_TICK);
    offer(1'b0, dag_pkg::ACT_TICK);
    offer(1'b1, dag_pkg::ACT_HIGH);
    offer(1'b1, ACT_SPARE);
    drain();

    // Full-scale steps: saturate in one tick, clear in one tick
    write_all(32'(FULL_SCALE));
    offer(1'b1, dag_pkg::ACT_TICK);
    offer(1'b1, dag_pkg::ACT_TICK);
    offer(1'b1, dag_pkg::ACT_HIGH);
    offer(1'b1, dag_pkg::ACT_LOW);
    offer(1'b1, dag_pkg::ACT_TICK);
    drain();

    // Zero steps: a rising gate holds, a falling gate at zero drops to low
    write_all('0);
    offer(1'b0, dag_pkg::ACT_HIGH);
    offer(1'b0, dag_pkg::ACT_TICK);
    offer(1'b0, dag_pkg::ACT_LOW);
    offer(1'b0, dag_pkg::ACT_TICK);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      apb_write(dag_pkg::REG_ATTACK_A, rand_step());
      apb_write(dag_pkg::REG_RELEASE_A, rand_step());
      apb_write(dag_pkg::REG_ATTACK_B, rand_step());
      apb_write(dag_pkg::REG_RELEASE_B, rand_step());
      quiet = (p == 0);
      if (p == 2) hold_request = 1'b1;
      burst = 0;
      ch = 1'b0;
      repeat (ITEMS_PER_PHASE) begin
        if (burst == 0) begin
          ch = 1'($urandom_range(0, 1));
          burst = $urandom_range(1, 8);
        end
        burst--;
        roll = $urandom_range(99);
        if (roll < 60) act = dag_pkg::ACT_TICK;
        else if (roll < 80) act = dag_pkg::ACT_HIGH;
        else act = dag_pkg::ACT_LOW;
        offer(ch, act);
      end
      drain();
    end
    quiet = 1'b0;

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
